/* src/assert_macros.svh */
// assertion macros used by the checker file
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property with asynchronous active-low reset disable
`define RSFL_ASSERT(label, clk_sig, rst_sig, prop, msg) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (prop)) else $error(msg);

// implication form: consequent on the same edge
`define RSFL_IMPLY(label, clk_sig, rst_sig, pre, post, msg) \
	`RSFL_ASSERT(label, clk_sig, rst_sig, (pre) |-> (post), msg)

// implication form: consequent on the next edge
`define RSFL_NEXT(label, clk_sig, rst_sig, pre, post, msg) \
	`RSFL_ASSERT(label, clk_sig, rst_sig, (pre) |=> (post), msg)

`endif

/* src/rsfl_pkg.sv */
// package for the record slot free list: sizes, codes and control structs
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rsfl_pkg;

	// store geometry
	localparam int SLOTS       = 64;
	localparam int RECORD_BITS = 64;

	// fixed field widths
	localparam int SLOT_W = 6;
	localparam int DATA_W = 64;
	localparam int LINK_W = 7;
	localparam int CMP_W  = 7;

	// derived widths
	localparam int IDX_W = $clog2(SLOTS);
	localparam int CNT_W = $clog2(SLOTS + 1);

	// free list empty marker
	localparam logic [LINK_W-1:0] NO_FREE = 7'h7f;

	typedef enum logic [1:0] {
		KIND_ADD    = 2'd0,
		KIND_DELETE = 2'd1,
		KIND_READ   = 2'd2,
		KIND_SCAN   = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_FULL      = 3'd1,
		ST_NOT_LIVE  = 3'd2,
		ST_BEYOND    = 3'd3,
		ST_NONE_LIVE = 3'd4
	} status_t;

	// commands from controller to datapath
	typedef struct packed {
		logic accept;
		logic load_result;
		logic scan_read;
		logic scan_step;
		logic scan_emit;
	} ctrl_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic out_free;
		logic scan_go;
		logic cur_live;
		logic more_live;
		logic idx_last;
	} dp_stat_t;

endpackage

`default_nettype wire

/* src/rsfl_if.sv */
// request and response channel interfaces for the record slot free list
// depends on rsfl_pkg
`timescale 1ns / 1ps
`default_nettype none

interface rsfl_req_if;
	import rsfl_pkg::*;

	logic                 valid;
	logic                 ready;
	kind_t                kind;
	logic [SLOT_W-1:0]    slot;
	logic [DATA_W-1:0]    record_data;

	modport source (output valid, kind, slot, record_data, input ready);
	modport sink   (input valid, kind, slot, record_data, output ready);
endinterface

interface rsfl_rsp_if;
	import rsfl_pkg::*;

	logic                 valid;
	logic                 ready;
	status_t              status;
	logic [SLOT_W-1:0]    result_slot;
	logic [DATA_W-1:0]    result_data;
	logic                 last;

	modport source (output valid, status, result_slot, result_data, last, input ready);
	modport sink   (input valid, status, result_slot, result_data, last, output ready);
endinterface

`default_nettype wire

/* src/rsfl_ram.sv */
// generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module rsfl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read, held between reads
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

`default_nettype wire

/* src/rsfl_datapath.sv */
// datapath: record and link rams, live flags, free list head, used count,
// scan index and output register; depends on rsfl_pkg and rsfl_ram
`timescale 1ns / 1ps
`default_nettype none

module rsfl_datapath (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire rsfl_pkg::ctrl_cmd_t         cmd,
	output rsfl_pkg::dp_stat_t               stat,
	input  wire rsfl_pkg::kind_t             req_kind,
	input  wire logic [rsfl_pkg::SLOT_W-1:0] req_slot,
	input  wire logic [rsfl_pkg::DATA_W-1:0] req_data,
	input  wire logic                        rsp_ready,
	output logic                             rsp_valid,
	output rsfl_pkg::status_t                rsp_status,
	output logic [rsfl_pkg::SLOT_W-1:0]      rsp_slot,
	output logic [rsfl_pkg::DATA_W-1:0]      rsp_data,
	output logic                             rsp_last
);
	import rsfl_pkg::*;

	logic [SLOTS-1:0]       live_q;
	logic [LINK_W-1:0]      head_q;
	logic [CNT_W-1:0]       used_q;
	logic [IDX_W-1:0]       idx_q;
	status_t                res_status_q;
	logic [SLOT_W-1:0]      res_slot_q;
	logic                   res_ram_q;
	logic                   res_pop_q;
	logic                   out_valid_q;
	status_t                out_status_q;
	logic [SLOT_W-1:0]      out_slot_q;
	logic [DATA_W-1:0]      out_data_q;
	logic                   out_last_q;

	logic                   slot_in_range;
	logic [IDX_W-1:0]       slot_idx;
	logic                   head_valid;
	logic [IDX_W-1:0]       head_idx;
	logic                   can_append;
	logic [IDX_W-1:0]       add_idx;
	logic                   slot_live;
	logic [SLOTS-1:0]       above_mask;

	logic                   rec_we;
	logic                   rec_re;
	logic [IDX_W-1:0]       rec_raddr;
	logic [RECORD_BITS-1:0] rec_rdata;
	logic                   link_we;
	logic                   link_re;
	logic [LINK_W-1:0]      link_rdata;

	// request decode against current state
	assign slot_in_range = (CMP_W'(req_slot) < CMP_W'(used_q))
		&& (CMP_W'(req_slot) < CMP_W'(SLOTS));
	assign slot_idx   = req_slot[IDX_W-1:0];
	assign head_valid = (head_q != NO_FREE);
	assign head_idx   = head_q[IDX_W-1:0];
	assign can_append = (used_q < CNT_W'(SLOTS));
	assign add_idx    = head_valid ? head_idx : used_q[IDX_W-1:0];
	assign slot_live  = live_q[slot_idx];

	// live slots strictly above the scan index
	assign above_mask = ({SLOTS{1'b1}} << idx_q) << 1;

	// status towards the controller
	assign stat.out_free  = !out_valid_q || rsp_ready;
	assign stat.scan_go   = (req_kind == KIND_SCAN) && (|live_q);
	assign stat.cur_live  = live_q[idx_q];
	assign stat.more_live = |(live_q & above_mask);
	assign stat.idx_last  = (idx_q == IDX_W'(SLOTS - 1));

	// ram port controls
	assign rec_we    = cmd.accept && (req_kind == KIND_ADD) && (head_valid || can_append);
	assign rec_re    = (cmd.accept && (req_kind == KIND_READ)) || cmd.scan_read;
	assign rec_raddr = cmd.scan_read ? idx_q : slot_idx;
	assign link_we   = cmd.accept && (req_kind == KIND_DELETE) && slot_in_range && slot_live;
	assign link_re   = cmd.accept && (req_kind == KIND_ADD) && head_valid;

	rsfl_ram #(
		.WIDTH (RECORD_BITS),
		.DEPTH (SLOTS)
	) u_record_ram (
		.clk   (clk),
		.we    (rec_we),
		.waddr (add_idx),
		.wdata (req_data[RECORD_BITS-1:0]),
		.re    (rec_re),
		.raddr (rec_raddr),
		.rdata (rec_rdata)
	);

	rsfl_ram #(
		.WIDTH (LINK_W),
		.DEPTH (SLOTS)
	) u_link_ram (
		.clk   (clk),
		.we    (link_we),
		.waddr (slot_idx),
		.wdata (head_q),
		.re    (link_re),
		.raddr (head_idx),
		.rdata (link_rdata)
	);

	// store state, pending result and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q       <= '0;
			head_q       <= NO_FREE;
			used_q       <= '0;
			idx_q        <= '0;
			res_status_q <= ST_OK;
			res_slot_q   <= '0;
			res_ram_q    <= 1'b0;
			res_pop_q    <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.accept) begin
				// payload comes from the ram only for a read in range
				res_ram_q <= (req_kind == KIND_READ) && slot_in_range;
				res_pop_q <= (req_kind == KIND_ADD) && head_valid;
				unique case (req_kind)
					KIND_ADD: begin
						if (head_valid) begin
							live_q[add_idx] <= 1'b1;
							res_status_q    <= ST_OK;
							res_slot_q      <= SLOT_W'(add_idx);
						end else if (can_append) begin
							live_q[add_idx] <= 1'b1;
							used_q          <= used_q + CNT_W'(1);
							res_status_q    <= ST_OK;
							res_slot_q      <= SLOT_W'(add_idx);
						end else begin
							res_status_q <= ST_FULL;
							res_slot_q   <= '0;
						end
					end
					KIND_DELETE: begin
						if (!slot_in_range) begin
							res_status_q <= ST_BEYOND;
							res_slot_q   <= '0;
						end else if (!slot_live) begin
							res_status_q <= ST_NOT_LIVE;
							res_slot_q   <= '0;
						end else begin
							live_q[slot_idx] <= 1'b0;
							head_q           <= LINK_W'(req_slot);
							res_status_q     <= ST_OK;
							res_slot_q       <= req_slot;
						end
					end
					KIND_READ: begin
						if (!slot_in_range) begin
							res_status_q <= ST_BEYOND;
							res_slot_q   <= '0;
						end else begin
							res_status_q <= ST_OK;
							res_slot_q   <= req_slot;
						end
					end
					KIND_SCAN: begin
						// only reported when nothing is live
						idx_q        <= '0;
						res_status_q <= ST_NONE_LIVE;
						res_slot_q   <= '0;
					end
					default: begin
						res_status_q <= ST_OK;
						res_slot_q   <= '0;
					end
				endcase
			end
			// pop the free list once the link has been read
			if (cmd.load_result && res_pop_q) begin
				head_q <= link_rdata;
			end
			if (cmd.scan_step) begin
				idx_q <= idx_q + IDX_W'(1);
			end
			if (cmd.load_result || cmd.scan_emit) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output payload register
	always_ff @(posedge clk) begin
		if (cmd.load_result) begin
			out_status_q <= res_status_q;
			out_slot_q   <= res_slot_q;
			out_data_q   <= res_ram_q ? DATA_W'(rec_rdata) : '0;
			out_last_q   <= 1'b1;
		end else if (cmd.scan_emit) begin
			out_status_q <= ST_OK;
			out_slot_q   <= SLOT_W'(idx_q);
			out_data_q   <= DATA_W'(rec_rdata);
			out_last_q   <= !stat.more_live;
		end
	end

	assign rsp_valid  = out_valid_q;
	assign rsp_status = out_status_q;
	assign rsp_slot   = out_slot_q;
	assign rsp_data   = out_data_q;
	assign rsp_last   = out_last_q;
endmodule

`default_nettype wire

/* src/rsfl_ctrl.sv */
// controller: sequences accept, result load and the live record scan
// depends on rsfl_pkg
`timescale 1ns / 1ps
`default_nettype none

module rsfl_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                req_valid,
	output logic                     req_ready,
	input  wire rsfl_pkg::dp_stat_t  stat,
	output rsfl_pkg::ctrl_cmd_t      cmd
);
	import rsfl_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_RESP,
		S_SCAN_LOOK,
		S_SCAN_EMIT
	} state_t;

	state_t state_q;

	// commands decoded from state and datapath status
	always_comb begin
		cmd       = '0;
		req_ready = (state_q == S_IDLE);
		unique case (state_q)
			S_IDLE: begin
				cmd.accept = req_valid;
			end
			S_RESP: begin
				cmd.load_result = stat.out_free;
			end
			S_SCAN_LOOK: begin
				if (stat.cur_live) begin
					cmd.scan_read = 1'b1;
				end else if (!stat.idx_last) begin
					cmd.scan_step = 1'b1;
				end
			end
			S_SCAN_EMIT: begin
				if (stat.out_free) begin
					cmd.scan_emit = 1'b1;
					cmd.scan_step = stat.more_live;
				end
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						state_q <= stat.scan_go ? S_SCAN_LOOK : S_RESP;
					end
				end
				S_RESP: begin
					if (stat.out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_SCAN_LOOK: begin
					if (stat.cur_live) begin
						state_q <= S_SCAN_EMIT;
					end else if (stat.idx_last) begin
						state_q <= S_IDLE;
					end
				end
				S_SCAN_EMIT: begin
					if (stat.out_free) begin
						state_q <= stat.more_live ? S_SCAN_LOOK : S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule

`default_nettype wire

/* src/record_slot_free_list_core.sv */
// add, delete, read: result registered at accept, then loaded into the output
// register once it is free; the next item is taken only after that load
// scan: each empty slot is passed and each live slot read and then emitted, up to the
// highest live slot; a single record ram read port serves each emitted item
// reset clears live flags, used count and the free list; the record and link
// rams are not cleared and need no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module record_slot_free_list_core (
	input  wire logic clk,
	input  wire logic arst_n,
	rsfl_req_if.sink  req,
	rsfl_rsp_if.source rsp
);
	import rsfl_pkg::*;

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	// sequencing
	rsfl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// storage and output register
	rsfl_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.req_kind   (req.kind),
		.req_slot   (req.slot),
		.req_data   (req.record_data),
		.rsp_ready  (rsp.ready),
		.rsp_valid  (rsp.valid),
		.rsp_status (rsp.status),
		.rsp_slot   (rsp.result_slot),
		.rsp_data   (rsp.result_data),
		.rsp_last   (rsp.last)
	);
endmodule

`default_nettype wire

/* src/rsfl_checker.sv */
// port level checks for the record slot free list, bound to the top level
// depends on rsfl_pkg and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module rsfl_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        req_valid,
	input wire logic                        req_ready,
	input wire logic                        rsp_valid,
	input wire logic                        rsp_ready,
	input wire rsfl_pkg::status_t           rsp_status,
	input wire logic [rsfl_pkg::SLOT_W-1:0] rsp_slot,
	input wire logic [rsfl_pkg::DATA_W-1:0] rsp_data,
	input wire logic                        rsp_last
);
	import rsfl_pkg::*;

	// a stalled item holds
	`RSFL_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data) && $stable(rsp_slot) && $stable(rsp_last), "stalled response item changed")

	// one item at a time: ready drops after an accept
	`RSFL_NEXT(a_one_in_flight, clk, arst_n, req_valid && req_ready, !req_ready, "request accepted while previous item in flight")

	// failures carry zeroed fields and close the item
	`RSFL_IMPLY(a_fail_fields, clk, arst_n, rsp_valid && (rsp_status != ST_OK), rsp_last && (rsp_slot == '0) && (rsp_data == '0), "failing response item has stray fields")

	// only scan results run on without last, and those are always ok
	`RSFL_IMPLY(a_nonlast_ok, clk, arst_n, rsp_valid && !rsp_last, rsp_status == ST_OK, "non-final response item not ok")
endmodule

bind record_slot_free_list_core rsfl_checker u_rsfl_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.rsp_status (rsp.status),
	.rsp_slot   (rsp.result_slot),
	.rsp_data   (rsp.result_data),
	.rsp_last   (rsp.last)
);

`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 1ps
// self-checking bench for record_slot_free_list_core: directed items, then phased random traffic
// depends on rsfl_pkg, the rsfl_req_if / rsfl_rsp_if interfaces and the core itself

module testbench;
	import rsfl_pkg::*;

	localparam int ITEM_TARGET  = 350;
	localparam int CYCLE_LIMIT  = 600000;
	localparam int DRAIN_CYCLES = 16;
	localparam logic [DATA_W-1:0] DATA_KEEP = {DATA_W{1'b1}} >> (DATA_W - RECORD_BITS);

	typedef struct {
		kind_t             kind;
		logic [SLOT_W-1:0] slot;
		logic [DATA_W-1:0] data;
	} store_op_t;

	typedef struct {
		status_t           status;
		logic [SLOT_W-1:0] slot;
		logic [DATA_W-1:0] data;
		logic              last;
	} store_reply_t;

	typedef enum int {
		MIX_GROW,
		MIX_CHURN,
		MIX_SHRINK
	} mix_t;

	logic clk;
	logic arst_n;

	rsfl_req_if req_ch ();
	rsfl_rsp_if rsp_ch ();

	record_slot_free_list_core u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// shadow of the store
	logic [DATA_W-1:0] slot_records [SLOTS];
	logic [LINK_W-1:0] slot_links [SLOTS];
	logic              slot_live [SLOTS];
	logic [LINK_W-1:0] free_top;
	int                appended;

	store_op_t    op_backlog [$];
	store_reply_t store_replies [$];

	int issued_cnt = 0;
	int taken_cnt  = 0;
	int reply_cnt  = 0;
	int scan_cnt   = 0;
	int full_hits  = 0;
	int errors     = 0;
	int planned    = 0;
	int cycle_cnt  = 0;

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic queue_reply(input status_t st, input logic [SLOT_W-1:0] s,
			input logic [DATA_W-1:0] d, input logic lst);
		store_reply_t r;
		r.status = st;
		r.slot   = s;
		r.data   = d;
		r.last   = lst;
		store_replies.insert(store_replies.size(), r);
	endtask

	// advance the shadow store by one accepted item and queue what it should answer
	task automatic apply_store_op(input store_op_t op);
		logic [LINK_W-1:0] pick;
		int                emitted;
		int                s;
		emitted = 0;
		case (op.kind)
			KIND_ADD: begin
				// lifo reuse first, then append, else full
				if (free_top < SLOTS) begin
					pick     = free_top;
					free_top = slot_links[pick];
				end else if (appended < SLOTS) begin
					pick = LINK_W'(appended);
					appended++;
				end else begin
					pick = NO_FREE;
				end
				if (pick == NO_FREE) begin
					full_hits++;
					queue_reply(ST_FULL, '0, '0, 1'b1);
				end else begin
					slot_records[pick] = op.data & DATA_KEEP;
					slot_live[pick]    = 1'b1;
					queue_reply(ST_OK, pick[SLOT_W-1:0], '0, 1'b1);
				end
			end
			KIND_DELETE: begin
				if (op.slot >= appended) begin
					queue_reply(ST_BEYOND, '0, '0, 1'b1);
				end else if (!slot_live[op.slot]) begin
					queue_reply(ST_NOT_LIVE, '0, '0, 1'b1);
				end else begin
					slot_links[op.slot] = free_top;
					free_top            = LINK_W'(op.slot);
					slot_live[op.slot]  = 1'b0;
					queue_reply(ST_OK, op.slot, '0, 1'b1);
				end
			end
			KIND_READ: begin
				// a freed slot below the used mark still returns its old payload
				if (op.slot >= appended)
					queue_reply(ST_BEYOND, '0, '0, 1'b1);
				else
					queue_reply(ST_OK, op.slot, slot_records[op.slot], 1'b1);
			end
			default: begin
				scan_cnt++;
				for (s = 0; s < SLOTS; s++) begin
					if (slot_live[s]) begin
						queue_reply(ST_OK, SLOT_W'(s), slot_records[s], 1'b0);
						emitted++;
					end
				end
				if (emitted == 0)
					queue_reply(ST_NONE_LIVE, '0, '0, 1'b1);
				else
					store_replies[store_replies.size() - 1].last = 1'b1;
			end
		endcase
	endtask

	task automatic stage(input kind_t k, input int s, input logic [DATA_W-1:0] d);
		store_op_t op;
		op.kind = k;
		op.slot = SLOT_W'(s);
		op.data = d;
		op_backlog.insert(op_backlog.size(), op);
		planned++;
	endtask

	function automatic logic [DATA_W-1:0] rand_word();
		return {$urandom, $urandom};
	endfunction

	// mostly live slots, some below the used mark, some anywhere
	function automatic int pick_slot(input int live_list[$], input int used);
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 70 && live_list.size() > 0)
			return live_list[$urandom_range(0, live_list.size() - 1)];
		if (roll < 85 && used > 0)
			return $urandom_range(0, used - 1);
		return $urandom_range(0, SLOTS - 1);
	endfunction

	// one phase of random items, slots chosen from the store as it stands now
	task automatic plan_phase(input mix_t mix, input int count);
		int live_list [$];
		int roll;
		int add_w;
		int del_w;
		int read_w;
		int s;
		int i;
		for (s = 0; s < SLOTS; s++)
			if (slot_live[s])
				live_list.insert(live_list.size(), s);
		case (mix)
			MIX_GROW: begin
				add_w = 60; del_w = 20; read_w = 13;
			end
			MIX_CHURN: begin
				add_w = 35; del_w = 35; read_w = 22;
			end
			default: begin
				add_w = 12; del_w = 68; read_w = 13;
			end
		endcase
		for (i = 0; i < count; i++) begin
			roll = $urandom_range(0, 99);
			if (roll < add_w)
				stage(KIND_ADD, $urandom_range(0, SLOTS - 1), rand_word());
			else if (roll < add_w + del_w)
				stage(KIND_DELETE, pick_slot(live_list, appended), rand_word());
			else if (roll < add_w + del_w + read_w)
				stage(KIND_READ, pick_slot(live_list, appended), rand_word());
			else
				stage(KIND_SCAN, $urandom_range(0, SLOTS - 1), rand_word());
		end
	endtask

	// fill every free and unused slot, run into the full case, then work the top slot
	task automatic plan_fill();
		int n_live;
		int s;
		int i;
		n_live = 0;
		for (s = 0; s < SLOTS; s++)
			if (slot_live[s])
				n_live++;
		for (i = 0; i < SLOTS - n_live + 3; i++)
			stage(KIND_ADD, $urandom_range(0, SLOTS - 1), rand_word());
		stage(KIND_READ, SLOTS - 1, rand_word());
		stage(KIND_SCAN, 0, rand_word());
		stage(KIND_DELETE, SLOTS - 1, rand_word());
		stage(KIND_READ, SLOTS - 1, rand_word());
		stage(KIND_DELETE, SLOTS - 1, rand_word());
		stage(KIND_ADD, 0, {DATA_W{1'b1}});
		stage(KIND_ADD, SLOTS - 1, '0);
	endtask

	task automatic wait_idle();
		while (op_backlog.size() > 0 || taken_cnt != issued_cnt || store_replies.size() > 0)
			@(negedge clk);
	endtask

	// sender: bursts of random length with random gaps
	int burst_left = 5;
	int gap_left   = 0;

	always @(negedge clk) begin
		store_op_t op;
		if (arst_n && (!req_ch.valid || taken_cnt == issued_cnt)) begin
			if (gap_left > 0) begin
				gap_left--;
				req_ch.valid <= 1'b0;
			end else if (op_backlog.size() > 0) begin
				op = op_backlog.pop_front();
				req_ch.kind        <= op.kind;
				req_ch.slot        <= op.slot;
				req_ch.record_data <= op.data;
				req_ch.valid       <= 1'b1;
				issued_cnt++;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
						: $urandom_range(1, 8);
					gap_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20)
						: $urandom_range(0, 4);
				end
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// receiver: runs of ready broken by short stalls, now and then a long clean run
	int run_left  = 3;
	int hold_left = 0;

	always @(negedge clk) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= 1'b1;
			if (run_left > 0) begin
				run_left--;
			end else begin
				run_left  = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
					: $urandom_range(1, 10);
				hold_left = $urandom_range(1, 4);
			end
		end
	end

	// monitor: predict on accepted items, check accepted results against the oldest
	always @(posedge clk) begin
		store_op_t    op;
		store_reply_t exp_r;
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready) begin
				op.kind = req_ch.kind;
				op.slot = req_ch.slot;
				op.data = req_ch.record_data;
				apply_store_op(op);
				taken_cnt++;
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				reply_cnt++;
				if (store_replies.size() == 0) begin
					errors++;
					$display("%0t: result with nothing expected: status=%0d slot=%0d data=%h last=%b",
						$time, rsp_ch.status, rsp_ch.result_slot, rsp_ch.result_data,
						rsp_ch.last);
				end else begin
					exp_r = store_replies.pop_front();
					if (rsp_ch.status !== exp_r.status || rsp_ch.result_slot !== exp_r.slot
							|| rsp_ch.result_data !== exp_r.data || rsp_ch.last !== exp_r.last) begin
						errors++;
						$display("%0t: mismatch: expected status=%0d slot=%0d data=%h last=%b",
							$time, exp_r.status, exp_r.slot, exp_r.data, exp_r.last);
						$display("%0t:           actual status=%0d slot=%0d data=%h last=%b",
							$time, rsp_ch.status, rsp_ch.result_slot, rsp_ch.result_data,
							rsp_ch.last);
					end
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time, store_replies.size());
			$display("status: fail");
			$finish;
		end
	end

	// reset, directed items, then random phases
	initial begin
		int s;
		mix_t mix;
		bit filled;
		filled             = 1'b0;
		clk                = 1'b0;
		arst_n             = 1'b0;
		req_ch.valid       = 1'b0;
		req_ch.kind        = KIND_ADD;
		req_ch.slot        = '0;
		req_ch.record_data = '0;
		rsp_ch.ready       = 1'b0;
		for (s = 0; s < SLOTS; s++)
			slot_live[s] = 1'b0;
		free_top = NO_FREE;
		appended = 0;

		// empty store, out-of-range access, appends, deletes, lifo reuse
		stage(KIND_SCAN, 0, rand_word());
		stage(KIND_READ, 0, rand_word());
		stage(KIND_DELETE, 0, rand_word());
		stage(KIND_ADD, 0, {DATA_W{1'b1}});
		stage(KIND_ADD, 0, '0);
		stage(KIND_ADD, SLOTS - 1, rand_word());
		stage(KIND_READ, 0, rand_word());
		stage(KIND_READ, 1, rand_word());
		stage(KIND_DELETE, 1, rand_word());
		stage(KIND_DELETE, 1, rand_word());
		stage(KIND_READ, 1, rand_word());
		stage(KIND_DELETE, SLOTS - 1, rand_word());
		stage(KIND_READ, SLOTS - 1, rand_word());
		stage(KIND_SCAN, SLOTS - 1, rand_word());
		stage(KIND_DELETE, 0, rand_word());
		stage(KIND_ADD, 0, rand_word());
		stage(KIND_ADD, 0, rand_word());
		stage(KIND_ADD, 0, rand_word());
		stage(KIND_READ, 3, rand_word());
		stage(KIND_SCAN, 0, rand_word());

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (planned < ITEM_TARGET) begin
			wait_idle();
			@(posedge clk);
			if (!filled && planned >= 120) begin
				plan_fill();
				filled = 1'b1;
			end else begin
				mix = mix_t'($urandom_range(0, 2));
				plan_phase(mix, $urandom_range(15, 30));
			end
		end

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (store_replies.size() > 0) begin
			errors++;
			$display("%0t: %0d expected results never arrived", $time, store_replies.size());
		end
		$display("ran %0d items (%0d scans, %0d adds refused as full) giving %0d results",
			taken_cnt, scan_cnt, full_hits, reply_cnt);
		$display("mismatches and stray results: %0d", errors);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
